>>> src/fgsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgsq_pkg: shared types and constants for the friend graph query block
// widths of the item fields, request kinds, controller states and the
// command / status bundles between controller and datapath
// ----------------------------------------------------------------------------
package fgsq_pkg;

    // field widths
    localparam int KIND_W      = 3;
    localparam int ID_W        = 6;
    localparam int COUNT_W     = 7;
    localparam int ROW_W       = 64;
    localparam int ID_SPACE_DEF = 64;

    // bit counter slices a row into lanes, one lane per cycle
    localparam int PC_LANE     = 8;
    localparam int PC_STEPS    = ROW_W / PC_LANE;
    localparam int PC_STEP_W   = $clog2(PC_STEPS);
    localparam int LANE_SUM_W  = $clog2(PC_LANE + 1);

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR     = 3'd0,
        KIND_DECLARE   = 3'd1,
        KIND_ADD       = 3'd2,
        KIND_MUTUAL    = 3'd3,
        KIND_UNIQUE    = 3'd4,
        KIND_STRANGERS = 3'd5
    } kind_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_WR,
        S_ROW_A,
        S_ROW_B,
        S_WALK,
        S_DRAIN,
        S_LOAD,
        S_COUNT,
        S_PUT
    } state_t;

    // read address source
    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_WALK
    } rd_src_t;

    // bit counter source
    typedef enum logic [1:0] {
        PC_MUTUAL,
        PC_UNIQUE,
        PC_STRANGERS
    } pc_src_t;

    // controller to datapath
    typedef struct packed {
        logic    latch;
        logic    clear_rec;
        logic    declare;
        logic    rd_en;
        rd_src_t rd_src;
        logic    wr_add;
        logic    row_a_take;
        logic    pc_load;
        pc_src_t pc_src;
        logic    pc_step;
        logic    put;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  a_present;
        logic  b_ok;
        logic  out_full;
    } status_t;

endpackage

>>> src/fgsq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgsq_req_if: request channel
// valid / ready handshake carrying kind and two node ids
// ----------------------------------------------------------------------------
interface fgsq_req_if;
    logic                          valid;
    logic                          ready;
    logic [fgsq_pkg::KIND_W-1:0]   kind;
    logic [fgsq_pkg::ID_W-1:0]     node_a;
    logic [fgsq_pkg::ID_W-1:0]     node_b;

    modport source (output valid, output kind, output node_a, output node_b, input ready);
    modport sink   (input valid, input kind, input node_a, input node_b, output ready);
endinterface

>>> src/fgsq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgsq_rsp_if: response channel
// valid / ready handshake carrying one query count
// ----------------------------------------------------------------------------
interface fgsq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fgsq_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

>>> src/fgsq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgsq_ctrl: sequencer of the friend graph query block
// decodes one request, walks the adjacency rows and steps the bit counter
// ----------------------------------------------------------------------------
module fgsq_ctrl #(
    parameter int ID_SPACE = fgsq_pkg::ID_SPACE_DEF,
    parameter int NODES    = (ID_SPACE < fgsq_pkg::ROW_W) ? ID_SPACE : fgsq_pkg::ROW_W,
    parameter int ADDR_W   = $clog2(NODES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  fgsq_pkg::status_t   st,
    output fgsq_pkg::cmd_t      cmd,
    output logic [ADDR_W-1:0]   walk_idx
);

    fgsq_pkg::state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]                walk_idx_reg, walk_idx_next;
    logic [fgsq_pkg::PC_STEP_W-1:0]   step_reg, step_next;
    logic                             walk_last;
    logic                             step_last;

    assign walk_last = (walk_idx_reg == ADDR_W'(NODES - 1));
    assign step_last = (step_reg == fgsq_pkg::PC_STEP_W'(fgsq_pkg::PC_STEPS - 1));
    assign walk_idx  = walk_idx_reg;
    assign req_ready = (state_reg == fgsq_pkg::S_IDLE);

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fgsq_pkg::S_IDLE;
            walk_idx_reg <= '0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_idx_reg <= walk_idx_next;
            step_reg     <= step_next;
        end
    end

    // walk and step counters
    always_comb
    begin
        walk_idx_next = (state_reg == fgsq_pkg::S_WALK) ? walk_idx_reg + 1'b1 : '0;
        step_next     = (state_reg == fgsq_pkg::S_COUNT) ? step_reg + 1'b1 : '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fgsq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = fgsq_pkg::S_DECODE;
                end
            end
            fgsq_pkg::S_DECODE:
            begin
                unique case (st.kind)
                    fgsq_pkg::KIND_ADD:
                    begin
                        state_next = (st.a_present && st.b_ok) ? fgsq_pkg::S_ADD_WR
                                                               : fgsq_pkg::S_IDLE;
                    end
                    fgsq_pkg::KIND_MUTUAL,
                    fgsq_pkg::KIND_UNIQUE,
                    fgsq_pkg::KIND_STRANGERS:
                    begin
                        state_next = fgsq_pkg::S_ROW_A;
                    end
                    default:
                    begin
                        state_next = fgsq_pkg::S_IDLE;
                    end
                endcase
            end
            fgsq_pkg::S_ADD_WR:
            begin
                state_next = fgsq_pkg::S_IDLE;
            end
            fgsq_pkg::S_ROW_A:
            begin
                state_next = (st.kind == fgsq_pkg::KIND_MUTUAL) ? fgsq_pkg::S_ROW_B
                                                                : fgsq_pkg::S_WALK;
            end
            fgsq_pkg::S_ROW_B:
            begin
                state_next = fgsq_pkg::S_COUNT;
            end
            fgsq_pkg::S_WALK:
            begin
                if (walk_last)
                begin
                    state_next = fgsq_pkg::S_DRAIN;
                end
            end
            fgsq_pkg::S_DRAIN:
            begin
                state_next = fgsq_pkg::S_LOAD;
            end
            fgsq_pkg::S_LOAD:
            begin
                state_next = fgsq_pkg::S_COUNT;
            end
            fgsq_pkg::S_COUNT:
            begin
                if (step_last)
                begin
                    state_next = fgsq_pkg::S_PUT;
                end
            end
            fgsq_pkg::S_PUT:
            begin
                if (!st.out_full)
                begin
                    state_next = fgsq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fgsq_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            fgsq_pkg::S_IDLE:
            begin
                cmd.latch = req_valid;
            end
            fgsq_pkg::S_DECODE:
            begin
                unique case (st.kind)
                    fgsq_pkg::KIND_CLEAR:
                    begin
                        cmd.clear_rec = 1'b1;
                    end
                    fgsq_pkg::KIND_DECLARE:
                    begin
                        cmd.declare = 1'b1;
                    end
                    fgsq_pkg::KIND_ADD:
                    begin
                        cmd.rd_en  = st.a_present && st.b_ok;
                        cmd.rd_src = fgsq_pkg::RD_A;
                    end
                    fgsq_pkg::KIND_MUTUAL,
                    fgsq_pkg::KIND_UNIQUE,
                    fgsq_pkg::KIND_STRANGERS:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = fgsq_pkg::RD_A;
                    end
                    default:
                    begin
                        cmd.rd_en = 1'b0;
                    end
                endcase
            end
            fgsq_pkg::S_ADD_WR:
            begin
                cmd.wr_add = 1'b1;
            end
            fgsq_pkg::S_ROW_A:
            begin
                cmd.row_a_take = 1'b1;
                if (st.kind == fgsq_pkg::KIND_MUTUAL)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = fgsq_pkg::RD_B;
                end
            end
            fgsq_pkg::S_ROW_B:
            begin
                cmd.pc_load = 1'b1;
                cmd.pc_src  = fgsq_pkg::PC_MUTUAL;
            end
            fgsq_pkg::S_WALK:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = fgsq_pkg::RD_WALK;
            end
            fgsq_pkg::S_DRAIN:
            begin
                cmd.rd_en = 1'b0;
            end
            fgsq_pkg::S_LOAD:
            begin
                cmd.pc_load = 1'b1;
                cmd.pc_src  = (st.kind == fgsq_pkg::KIND_UNIQUE) ? fgsq_pkg::PC_UNIQUE
                                                                 : fgsq_pkg::PC_STRANGERS;
            end
            fgsq_pkg::S_COUNT:
            begin
                cmd.pc_step = 1'b1;
            end
            fgsq_pkg::S_PUT:
            begin
                cmd.put = !st.out_full;
            end
            default:
            begin
                cmd.put = 1'b0;
            end
        endcase
    end

endmodule

>>> src/fgsq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgsq_datapath: adjacency row memory, record marks, set accumulators,
// lane-serial bit counter and response register
// ----------------------------------------------------------------------------
module fgsq_datapath #(
    parameter int ID_SPACE = fgsq_pkg::ID_SPACE_DEF,
    parameter int NODES    = (ID_SPACE < fgsq_pkg::ROW_W) ? ID_SPACE : fgsq_pkg::ROW_W,
    parameter int ADDR_W   = $clog2(NODES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fgsq_pkg::KIND_W-1:0]   req_kind,
    input  logic [fgsq_pkg::ID_W-1:0]     req_node_a,
    input  logic [fgsq_pkg::ID_W-1:0]     req_node_b,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    output logic [fgsq_pkg::COUNT_W-1:0]  rsp_count,
    input  fgsq_pkg::cmd_t                cmd,
    input  logic [ADDR_W-1:0]             walk_idx,
    output fgsq_pkg::status_t             st
);

    localparam int ROW_W = fgsq_pkg::ROW_W;
    localparam int ID_W  = fgsq_pkg::ID_W;

    // adjacency rows, valid only where the record mark is set
    logic [ROW_W-1:0]              mem [NODES];

    fgsq_pkg::kind_t               kind_reg;
    logic [ID_W-1:0]               node_a_reg;
    logic [ID_W-1:0]               node_b_reg;
    logic [ROW_W-1:0]              present_reg;
    logic [ROW_W-1:0]              rd_row_reg;
    logic                          rd_hit_reg;
    logic                          rd_walk_reg;
    logic [ID_W-1:0]               rd_idx_reg;
    logic [ROW_W-1:0]              row_a_reg;
    logic [ROW_W-1:0]              others_reg;
    logic [ROW_W-1:0]              seen_reg;
    logic [ROW_W-1:0]              known_reg;
    logic [ROW_W-1:0]              pc_reg;
    logic [fgsq_pkg::COUNT_W-1:0]  cnt_reg;
    logic                          out_valid_reg;
    logic [fgsq_pkg::COUNT_W-1:0]  out_count_reg;

    logic [ID_W-1:0]               rd_idx;
    logic [ADDR_W-1:0]             rd_addr;
    logic [ROW_W-1:0]              row_m;
    logic [ROW_W-1:0]              bit_a;
    logic [ROW_W-1:0]              bit_b;
    logic [ROW_W-1:0]              pc_src_val;
    logic [fgsq_pkg::LANE_SUM_W-1:0] lane_sum;
    logic                          wr_en;
    logic [ROW_W-1:0]              wr_data;

    assign bit_a = ROW_W'(1) << node_a_reg;
    assign bit_b = ROW_W'(1) << node_b_reg;

    // masked row from the last read
    assign row_m = rd_hit_reg ? rd_row_reg : '0;

    // read address select
    always_comb
    begin
        unique case (cmd.rd_src)
            fgsq_pkg::RD_A:    rd_idx = node_a_reg;
            fgsq_pkg::RD_B:    rd_idx = node_b_reg;
            fgsq_pkg::RD_WALK: rd_idx = ID_W'(walk_idx);
            default:           rd_idx = node_a_reg;
        endcase
    end
    assign rd_addr = rd_idx[ADDR_W-1:0];

    // row write: zero on declare, set friend bit on add
    assign wr_en   = (cmd.declare && !present_reg[node_a_reg] &&
                      ({1'b0, node_a_reg} < (ID_W + 1)'(NODES))) || cmd.wr_add;
    assign wr_data = cmd.declare ? '0 : (rd_row_reg | bit_b);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[node_a_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    // captured request
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg   <= fgsq_pkg::kind_t'(req_kind);
            node_a_reg <= req_node_a;
            node_b_reg <= req_node_b;
        end
    end

    // record marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else if (cmd.clear_rec)
        begin
            present_reg <= '0;
        end
        else if (wr_en && cmd.declare)
        begin
            present_reg <= present_reg | bit_a;
        end
    end

    // read tag: hit, walk flag and id of the row in rd_row_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_walk_reg <= 1'b0;
            rd_hit_reg  <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            rd_walk_reg <= cmd.rd_en && (cmd.rd_src == fgsq_pkg::RD_WALK);
            if (cmd.rd_en)
            begin
                rd_hit_reg <= present_reg[rd_idx];
                rd_idx_reg <= rd_idx;
            end
        end
    end

    // set accumulators over the row walk
    always_ff @(posedge clk)
    begin
        if (cmd.row_a_take)
        begin
            row_a_reg  <= row_m;
            others_reg <= '0;
            seen_reg   <= present_reg | bit_a;
            known_reg  <= row_m | bit_a;
        end
        else if (rd_walk_reg)
        begin
            if (rd_idx_reg != node_a_reg)
            begin
                others_reg <= others_reg | row_m;
            end
            seen_reg <= seen_reg | row_m;
            if (row_a_reg[rd_idx_reg])
            begin
                known_reg <= known_reg | row_m;
            end
        end
    end

    // bit counter source
    always_comb
    begin
        unique case (cmd.pc_src)
            fgsq_pkg::PC_MUTUAL:    pc_src_val = row_a_reg & row_m;
            fgsq_pkg::PC_UNIQUE:    pc_src_val = row_a_reg & ~others_reg;
            fgsq_pkg::PC_STRANGERS: pc_src_val = seen_reg & ~known_reg;
            default:                pc_src_val = '0;
        endcase
    end

    // ones in the low lane
    always_comb
    begin
        lane_sum = '0;
        for (int i = 0; i < fgsq_pkg::PC_LANE; i++)
        begin
            lane_sum = lane_sum + fgsq_pkg::LANE_SUM_W'(pc_reg[i]);
        end
    end

    // lane-serial bit counter
    always_ff @(posedge clk)
    begin
        if (cmd.pc_load)
        begin
            pc_reg  <= pc_src_val;
            cnt_reg <= '0;
        end
        else if (cmd.pc_step)
        begin
            pc_reg  <= pc_reg >> fgsq_pkg::PC_LANE;
            cnt_reg <= cnt_reg + fgsq_pkg::COUNT_W'(lane_sum);
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            out_count_reg <= cnt_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_count = out_count_reg;

    // status to controller
    assign st.kind      = kind_reg;
    assign st.a_present = present_reg[node_a_reg];
    assign st.b_ok      = ({1'b0, node_b_reg} < (ID_W + 1)'(NODES));
    assign st.out_full  = out_valid_reg && !rsp_ready;

endmodule

>>> src/friend_graph_set_queries.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// friend_graph_set_queries: friendship graph with set-count queries
// adjacency bit rows per node, record marks, mutual / unique / stranger counts
//
//   channel   dir   fields                    meaning
//   req       in    kind, node_a, node_b      load or query request
//   rsp       out   count                     answer of a query request
//
// query time is set by the one-row-per-cycle walk of the adjacency memory
// read port (unique and strangers only) plus 8 bit counter steps.
// reset clears record marks, not rows; new users get a zeroed row on declare.
// one request at a time; a finished count waits in the response register
// while the next request is taken, stalling only when a second one is ready.
// ----------------------------------------------------------------------------
module friend_graph_set_queries #(
    parameter int ID_SPACE = fgsq_pkg::ID_SPACE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fgsq_req_if.sink     req,
    fgsq_rsp_if.source   rsp
);

    localparam int NODES  = (ID_SPACE < fgsq_pkg::ROW_W) ? ID_SPACE : fgsq_pkg::ROW_W;
    localparam int ADDR_W = $clog2(NODES);

    fgsq_pkg::cmd_t      cmd;
    fgsq_pkg::status_t   st;
    logic [ADDR_W-1:0]   walk_idx;
    logic                req_ready;

    assign req.ready = req_ready;

    // sequencer
    fgsq_ctrl #(
        .ID_SPACE (ID_SPACE),
        .NODES    (NODES),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd),
        .walk_idx  (walk_idx)
    );

    // rows, marks and counters
    fgsq_datapath #(
        .ID_SPACE (ID_SPACE),
        .NODES    (NODES),
        .ADDR_W   (ADDR_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_kind   (req.kind),
        .req_node_a (req.node_a),
        .req_node_b (req.node_b),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .rsp_count  (rsp.count),
        .cmd        (cmd),
        .walk_idx   (walk_idx),
        .st         (st)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the friend graph query block
// drives load and query requests through the request channel; a scoreboard
// class keeps its own copy of the graph and predicts every count
// directed graph cases first, then random build-and-query episodes with noise,
// through phases of sender gaps, receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;
    import fgsq_pkg::*;

    // request kinds that the block ignores
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_7 = 3'd7;

    localparam int RANDOM_PER_PHASE = 180;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int DRAIN_CYCLES     = 120;

    // handshake pressure phases
    typedef enum logic [2:0] {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH,
        PH_HOLD_OFF
    } traffic_phase_t;

    // ------------------------------------------------------------------------
    // graph scoreboard: shadow adjacency rows, user marks and pending counts
    // ------------------------------------------------------------------------
    class friend_graph_sb;
        logic [ROW_W-1:0]   friend_rows [ROW_W];
        logic [ROW_W-1:0]   user_marks;
        logic [COUNT_W-1:0] count_fifo [$];
        int                 mismatches;
        int                 counts_checked;
        int                 kind_seen [8];

        function new();
            foreach (friend_rows[i]) friend_rows[i] = '0;
            user_marks     = '0;
            mismatches     = 0;
            counts_checked = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        // friend set of a node, empty when it holds no record
        function logic [ROW_W-1:0] friends_of(logic [ID_W-1:0] id);
            return user_marks[id] ? friend_rows[id] : '0;
        endfunction

        // append one predicted count
        function void queue_count(logic [COUNT_W-1:0] value);
            count_fifo = {count_fifo, value};
        endfunction

        // apply one accepted request, queue the count it produces
        function void note_request(logic [KIND_W-1:0] k, logic [ID_W-1:0] a,
                                   logic [ID_W-1:0] b);
            logic [ROW_W-1:0] others;
            logic [ROW_W-1:0] seen;
            logic [ROW_W-1:0] known;
            logic [ROW_W-1:0] self_bit;
            logic [ROW_W-1:0] fr;
            kind_seen[k]++;
            self_bit = '0;
            self_bit[a] = 1'b1;
            case (k)
                KIND_CLEAR:
                begin
                    foreach (friend_rows[i]) friend_rows[i] = '0;
                    user_marks = '0;
                end
                KIND_DECLARE:
                    user_marks[a] = 1'b1;
                KIND_ADD:
                    if (user_marks[a]) friend_rows[a][b] = 1'b1;
                KIND_MUTUAL:
                    queue_count(COUNT_W'($countones(friends_of(a) & friends_of(b))));
                KIND_UNIQUE:
                begin
                    others = '0;
                    for (int u = 0; u < ROW_W; u++)
                        if (u != a) others |= friends_of(ID_W'(u));
                    queue_count(COUNT_W'($countones(friends_of(a) & ~others)));
                end
                KIND_STRANGERS:
                begin
                    fr    = friends_of(a);
                    seen  = user_marks | self_bit;
                    known = fr | self_bit;
                    for (int u = 0; u < ROW_W; u++)
                    begin
                        seen |= friends_of(ID_W'(u));
                        if (fr[u]) known |= friends_of(ID_W'(u));
                    end
                    queue_count(COUNT_W'($countones(seen & ~known)));
                end
                default:
                    ;
            endcase
        endfunction

        // compare one accepted count with the oldest prediction
        function void check_count(logic [COUNT_W-1:0] actual);
            logic [COUNT_W-1:0] expected;
            if (count_fifo.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: count with no query pending, expected none, actual %0d",
                         $time, actual);
                return;
            end
            expected = count_fifo.pop_front();
            counts_checked++;
            if (actual !== expected)
            begin
                mismatches++;
                $display("%0t ns: count mismatch, expected %0d, actual %0d",
                         $time, expected, actual);
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    traffic_phase_t phase;
    int             valid_sent;
    friend_graph_sb graph_sb;

    fgsq_req_if req_ch();
    fgsq_rsp_if rsp_ch();

    friend_graph_set_queries u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #16_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int src_idle_pct(traffic_phase_t ph);
        case (ph)
            PH_SRC_IDLE: return 51;
            PH_BOTH:     return 6;
            default:     return 0;
        endcase
    endfunction

    function automatic int snk_stall_pct(traffic_phase_t ph);
        case (ph)
            PH_SNK_STALL: return 51;
            PH_BOTH:      return 6;
            default:      return 0;
        endcase
    endfunction

    // receiver: random stalls, one long hold-off in the hold-off phase
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == PH_HOLD_OFF && !hold_done)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct(phase));
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            graph_sb.check_count(rsp_ch.count);
    end

    // offer one request, return once it is accepted
    task automatic send_req(logic [KIND_W-1:0] k, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct(phase))
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.kind   <= k;
        req_ch.node_a <= a;
        req_ch.node_b <= b;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        graph_sb.note_request(k, a, b);
        if (k <= KIND_STRANGERS) valid_sent++;
    endtask

    function automatic logic [ID_W-1:0] pool_id(int base, int span);
        return ID_W'(base + $urandom_range(0, span - 1));
    endfunction

    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom_range(0, ROW_W - 1));
    endfunction

    // directed graph: extremes, self friend, repeats, missing records, bad kinds
    task automatic run_directed();
        send_req(KIND_CLEAR, 6'd0, 6'd0);
        send_req(KIND_STRANGERS, 6'd0, 6'd63);
        send_req(KIND_DECLARE, 6'd0, 6'd63);
        send_req(KIND_DECLARE, 6'd63, 6'd0);
        send_req(KIND_DECLARE, 6'd5, 6'd0);
        send_req(KIND_ADD, 6'd0, 6'd63);
        send_req(KIND_ADD, 6'd0, 6'd5);
        send_req(KIND_ADD, 6'd0, 6'd0);
        send_req(KIND_ADD, 6'd63, 6'd5);
        send_req(KIND_ADD, 6'd5, 6'd1);
        send_req(KIND_ADD, 6'd0, 6'd63);
        send_req(KIND_ADD, 6'd9, 6'd1);
        send_req(KIND_DECLARE, 6'd0, 6'd42);
        send_req(KIND_MUTUAL, 6'd0, 6'd63);
        send_req(KIND_MUTUAL, 6'd63, 6'd0);
        send_req(KIND_MUTUAL, 6'd9, 6'd0);
        send_req(KIND_UNIQUE, 6'd0, 6'd0);
        send_req(KIND_UNIQUE, 6'd63, 6'd0);
        send_req(KIND_UNIQUE, 6'd9, 6'd0);
        send_req(KIND_STRANGERS, 6'd0, 6'd0);
        send_req(KIND_STRANGERS, 6'd63, 6'd0);
        send_req(KIND_STRANGERS, 6'd42, 6'd0);
        send_req(KIND_UNKNOWN_6, 6'd63, 6'd63);
        send_req(KIND_UNKNOWN_7, 6'd0, 6'd0);
    endtask

    // one random episode: build a graph over an id window and query it,
    // or a short burst of noise
    task automatic run_episode();
        logic [ID_W-1:0]   users [$];
        logic [ID_W-1:0]   a;
        logic [KIND_W-1:0] k;
        int                span;
        int                base;
        int                pick;
        pick = $urandom_range(0, 2);
        span = (pick == 0) ? 8 : (pick == 1) ? 16 : ROW_W;
        base = $urandom_range(0, ROW_W - span);
        if ($urandom_range(99) < 20)
        begin
            repeat ($urandom_range(1, 6))
                send_req(KIND_W'($urandom_range(0, KIND_UNKNOWN_7)), any_id(), any_id());
            return;
        end
        if ($urandom_range(99) < 40)
            send_req(KIND_CLEAR, any_id(), any_id());
        repeat ($urandom_range(1, (span < 24) ? span / 2 : 12))
        begin
            a = pool_id(base, span);
            users = {users, a};
            send_req(KIND_DECLARE, a, any_id());
        end
        repeat ($urandom_range(0, 3 * users.size() + 2))
        begin
            a = ($urandom_range(9) != 0) ? users[$urandom_range(0, users.size() - 1)]
                                          : pool_id(base, span);
            send_req(KIND_ADD, a, pool_id(base, span));
        end
        repeat ($urandom_range(1, 8))
        begin
            pick = $urandom_range(0, 2);
            k = (pick == 0) ? KIND_MUTUAL : (pick == 1) ? KIND_UNIQUE : KIND_STRANGERS;
            a = ($urandom_range(3) != 0) ? users[$urandom_range(0, users.size() - 1)]
                                         : pool_id(base, span);
            send_req(k, a, ($urandom_range(1) != 0) ? users[$urandom_range(0, users.size() - 1)]
                                                    : pool_id(base, span));
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int start;
        graph_sb      = new();
        phase         = PH_FREE;
        valid_sent    = 0;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.kind   = KIND_CLEAR;
        req_ch.node_a = '0;
        req_ch.node_b = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = PH_FREE; p <= PH_HOLD_OFF; p++)
        begin
            phase = traffic_phase_t'(p);
            start = valid_sent;
            while (valid_sent - start < RANDOM_PER_PHASE)
                run_episode();
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);

        // drain outstanding counts
        while (graph_sb.count_fifo.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d clear, %0d declare, %0d add, %0d unknown kind",
                 valid_sent + graph_sb.kind_seen[KIND_UNKNOWN_6] +
                 graph_sb.kind_seen[KIND_UNKNOWN_7],
                 graph_sb.kind_seen[KIND_CLEAR], graph_sb.kind_seen[KIND_DECLARE],
                 graph_sb.kind_seen[KIND_ADD],
                 graph_sb.kind_seen[KIND_UNKNOWN_6] + graph_sb.kind_seen[KIND_UNKNOWN_7]);
        $display("queries: %0d mutual, %0d unique, %0d strangers; %0d counts compared",
                 graph_sb.kind_seen[KIND_MUTUAL], graph_sb.kind_seen[KIND_UNIQUE],
                 graph_sb.kind_seen[KIND_STRANGERS], graph_sb.counts_checked);
        if (graph_sb.mismatches == 0 && graph_sb.count_fifo.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
